### rtl/core/ppws_pkg.sv
`default_nettype none
package ppws_pkg;

  localparam int OpW = 3;

  localparam logic [OpW-1:0] OP_PAL_WRITE  = 3'd0;
  localparam logic [OpW-1:0] OP_WIN_BEGIN  = 3'd1;
  localparam logic [OpW-1:0] OP_PIXEL      = 3'd2;
  localparam logic [OpW-1:0] OP_SCROLL     = 3'd3;
  localparam logic [OpW-1:0] OP_SCROLL_AREA = 3'd4;

  localparam logic [15:0] CMD_COLUMN      = 16'h002A;
  localparam logic [15:0] CMD_PAGE        = 16'h002B;
  localparam logic [15:0] CMD_MEM_WRITE   = 16'h002C;
  localparam logic [15:0] CMD_SCROLL      = 16'h0037;
  localparam logic [15:0] CMD_SCROLL_AREA = 16'h0033;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_WIN  = 2'd0;
  localparam kind_t KIND_PIX  = 2'd1;
  localparam kind_t KIND_SCR  = 2'd2;
  localparam kind_t KIND_AREA = 2'd3;

  typedef struct packed {
    logic        is_command;
    logic [15:0] word_value;
    logic        two_bytes;
    logic        end_of_transfer;
  } word_t;

endpackage
`default_nettype wire

### rtl/core/palette_pixel_window_streamer_unit.sv
`default_nettype none
// Channel  Direction  Handshake         Payload
// in       input      in_valid/in_stall     operation, window, pixel, color, scroll fields
// out      output     out_valid/out_stall   is_command, word_value, two_bytes, end_of_transfer
// cfg      input      cfg_valid/cfg_ready   panel_lines (10 bit)
//
// One request is taken per cycle when each produces at most one word and the output does
// not stall; a request producing more words holds the input until its last word is loaded
// into the single-word output register. Palette reads use a synchronous RAM; results pass
// the s1 and output registers. Synchronous active-low reset clears window state, the
// palette valid bits (entries read zero until written) and sets panel_lines to 320.
// out_stall holds the output register and, once the word expander is full, the input.
module palette_pixel_window_streamer_unit #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [ppws_pkg::OpW-1:0] in_operation,
  input  wire logic [9:0]             in_pos_x,
  input  wire logic [9:0]             in_pos_y,
  input  wire logic [9:0]             in_src_width,
  input  wire logic [9:0]             in_src_height,
  input  wire logic                   in_doubled,
  input  wire logic [7:0]             in_pixel_index,
  input  wire logic [15:0]            in_color,
  input  wire logic [9:0]             in_scroll_offset,
  input  wire logic [9:0]             in_area_top,
  input  wire logic [9:0]             in_area_bottom,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic                        out_is_command,
  output logic [15:0]                 out_word_value,
  output logic                        out_two_bytes,
  output logic                        out_end_of_transfer,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [9:0]             cfg_panel_lines
);
  import ppws_pkg::*;

  localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

  logic [15:0]                pal_mem_r [PALETTE_ENTRIES];
  logic [PALETTE_ENTRIES-1:0] pal_vld_r;
  logic [15:0]                rd_data_r;
  logic                       rd_ok_r;

  logic [9:0]  panel_r;
  logic        open_r, open_nxt;
  logic        scale_r, scale_nxt;
  logic [9:0]  row_len_r, row_len_nxt;
  logic [10:0] rows_exp_r, rows_exp_nxt;
  logic [9:0]  col_r, col_nxt;
  logic [10:0] row_r, row_nxt;

  logic        s1_vld_r;
  kind_t       s1_kind_r, kind_sel;
  logic [2:0]  s1_cnt_r, s1_end_r, end_sel;
  logic [15:0] s1_a_r, s1_b_r, s1_c_r, s1_d_r;
  logic [15:0] a_sel, b_sel, c_sel, d_sel;
  logic        s1_last_r, last_sel;
  logic        emit;

  logic        acc, out_load, s1_fin;
  logic        in_range, pix_ok;
  logic [AW-1:0] pal_addr;
  word_t       word_cur, out_r;
  logic        out_vld_r;
  logic [15:0] color_cur;

  logic [15:0] x16, y16, w16, h16, panel16;
  logic [10:0] wmul, hmul;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      panel_r <= 10'd320;
    end else if (cfg_valid) begin
      panel_r <= cfg_panel_lines;
    end
  end

  assign out_load = s1_vld_r && (!out_vld_r || !out_stall);
  assign s1_fin   = out_load && (s1_cnt_r == s1_end_r);
  assign in_stall = s1_vld_r && !s1_fin;
  assign acc      = in_valid && !in_stall;

  assign pal_addr = in_pixel_index[AW-1:0];
  assign in_range = {1'b0, in_pixel_index} < 9'(PALETTE_ENTRIES);
  assign pix_ok   = acc && (in_operation == OP_PIXEL) && open_r;

  always_ff @(posedge clk) begin
    if (acc && (in_operation == OP_PAL_WRITE) && in_range) begin
      pal_mem_r[pal_addr] <= in_color;
    end
    if (pix_ok) begin
      rd_data_r <= pal_mem_r[pal_addr];
      rd_ok_r   <= in_range && pal_vld_r[pal_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pal_vld_r <= '0;
    end else if (acc && (in_operation == OP_PAL_WRITE) && in_range) begin
      pal_vld_r[pal_addr] <= 1'b1;
    end
  end

  assign x16     = {6'd0, in_pos_x};
  assign y16     = {6'd0, in_pos_y};
  assign wmul    = in_doubled ? {in_src_width, 1'b0} : {1'b0, in_src_width};
  assign hmul    = in_doubled ? {in_src_height, 1'b0} : {1'b0, in_src_height};
  assign w16     = {5'd0, wmul};
  assign h16     = {5'd0, hmul};
  assign panel16 = {6'd0, panel_r};

  always_comb begin
    open_nxt     = open_r;
    scale_nxt    = scale_r;
    row_len_nxt  = row_len_r;
    rows_exp_nxt = rows_exp_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    emit         = 1'b0;
    kind_sel     = KIND_WIN;
    end_sel      = 3'd0;
    a_sel        = '0;
    b_sel        = '0;
    c_sel        = '0;
    d_sel        = '0;
    last_sel     = 1'b0;
    if (acc) begin
      unique case (in_operation)
        OP_WIN_BEGIN: begin
          emit         = 1'b1;
          kind_sel     = KIND_WIN;
          end_sel      = 3'd6;
          a_sel        = x16;
          b_sel        = x16 + w16 - 16'd1;
          c_sel        = y16;
          d_sel        = y16 + h16 - 16'd1;
          scale_nxt    = in_doubled;
          row_len_nxt  = in_src_width;
          rows_exp_nxt = hmul;
          col_nxt      = '0;
          row_nxt      = '0;
          open_nxt     = (in_src_width != '0) && (in_src_height != '0);
        end
        OP_PIXEL: begin
          if (open_r) begin
            emit     = 1'b1;
            kind_sel = KIND_PIX;
            end_sel  = scale_r ? 3'd1 : 3'd0;
            col_nxt  = col_r + 10'd1;
            if (col_nxt == row_len_r) begin
              col_nxt = '0;
              row_nxt = row_r + 11'd1;
              if (row_nxt == rows_exp_r) begin
                last_sel = 1'b1;
                open_nxt = 1'b0;
              end
            end
          end
        end
        OP_SCROLL: begin
          emit     = 1'b1;
          kind_sel = KIND_SCR;
          end_sel  = 3'd1;
          b_sel    = panel16 - {6'd0, in_scroll_offset};
        end
        OP_SCROLL_AREA: begin
          emit     = 1'b1;
          kind_sel = KIND_AREA;
          end_sel  = 3'd3;
          a_sel    = {6'd0, in_area_top};
          b_sel    = panel16 - {6'd0, in_area_top} - {6'd0, in_area_bottom};
          c_sel    = {6'd0, in_area_bottom};
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r     <= 1'b0;
      scale_r    <= 1'b0;
      row_len_r  <= '0;
      rows_exp_r <= '0;
      col_r      <= '0;
      row_r      <= '0;
    end else begin
      open_r     <= open_nxt;
      scale_r    <= scale_nxt;
      row_len_r  <= row_len_nxt;
      rows_exp_r <= rows_exp_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s1_cnt_r <= '0;
    end else if (emit) begin
      s1_vld_r <= 1'b1;
      s1_cnt_r <= '0;
    end else if (s1_fin) begin
      s1_vld_r <= 1'b0;
    end else if (out_load) begin
      s1_cnt_r <= s1_cnt_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      s1_kind_r <= kind_sel;
      s1_end_r  <= end_sel;
      s1_a_r    <= a_sel;
      s1_b_r    <= b_sel;
      s1_c_r    <= c_sel;
      s1_d_r    <= d_sel;
      s1_last_r <= last_sel;
    end
  end

  assign color_cur = rd_ok_r ? rd_data_r : '0;

  always_comb begin
    word_cur = '{is_command: 1'b0, word_value: '0, two_bytes: 1'b1, end_of_transfer: 1'b1};
    unique case (s1_kind_r)
      KIND_WIN: begin
        case (s1_cnt_r)
          3'd0:    word_cur.word_value = CMD_COLUMN;
          3'd1:    word_cur.word_value = s1_a_r;
          3'd2:    word_cur.word_value = s1_b_r;
          3'd3:    word_cur.word_value = CMD_PAGE;
          3'd4:    word_cur.word_value = s1_c_r;
          3'd5:    word_cur.word_value = s1_d_r;
          default: word_cur.word_value = CMD_MEM_WRITE;
        endcase
        if (s1_cnt_r == 3'd0 || s1_cnt_r == 3'd3 || s1_cnt_r == 3'd6) begin
          word_cur.is_command = 1'b1;
          word_cur.two_bytes  = 1'b0;
        end
      end
      KIND_PIX: begin
        word_cur.word_value      = color_cur;
        word_cur.end_of_transfer = s1_last_r && (s1_cnt_r == s1_end_r);
      end
      KIND_SCR: begin
        if (s1_cnt_r == 3'd0) begin
          word_cur.is_command = 1'b1;
          word_cur.two_bytes  = 1'b0;
          word_cur.word_value = CMD_SCROLL;
        end else begin
          word_cur.word_value = s1_b_r;
        end
      end
      KIND_AREA: begin
        case (s1_cnt_r)
          3'd0: begin
            word_cur.is_command = 1'b1;
            word_cur.two_bytes  = 1'b0;
            word_cur.word_value = CMD_SCROLL_AREA;
          end
          3'd1:    word_cur.word_value = s1_a_r;
          3'd2:    word_cur.word_value = s1_b_r;
          default: word_cur.word_value = s1_c_r;
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= word_cur;
    end
  end

  assign out_valid           = out_vld_r;
  assign out_is_command      = out_r.is_command;
  assign out_word_value      = out_r.word_value;
  assign out_two_bytes       = out_r.two_bytes;
  assign out_end_of_transfer = out_r.end_of_transfer;

endmodule
`default_nettype wire

### rtl/core/ppws_checker.sv
`default_nettype none
module ppws_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        out_is_command,
  input wire logic [15:0] out_word_value,
  input wire logic        out_two_bytes,
  input wire logic        out_end_of_transfer
);
  import ppws_pkg::*;

  a_cmd_framing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_command |-> !out_two_bytes && out_end_of_transfer)
    else $error("command word with wrong framing");

  a_cmd_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_command |->
      (out_word_value == CMD_COLUMN) || (out_word_value == CMD_PAGE) ||
      (out_word_value == CMD_MEM_WRITE) || (out_word_value == CMD_SCROLL) ||
      (out_word_value == CMD_SCROLL_AREA))
    else $error("unknown command code");

  a_data_two_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_command |-> out_two_bytes)
    else $error("data word sent as single byte");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word_value))
    else $error("stalled output changed");

endmodule

bind palette_pixel_window_streamer_unit ppws_checker u_ppws_checker (.*);
`default_nettype wire
